// ----- hdl/serial_frame_deframer_assert.svh -----
// ---------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Concurrent assertion wrappers, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfd assertion failed");

// condition must never be true out of reset
`define SFD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sfd forbidden condition seen");

`else

`define SFD_ASSERT(lbl, prop)
`define SFD_NEVER(lbl, cond)

`endif

`endif

// ----- hdl/sfd_pkg.sv -----
// ---------------------------------------------------------------------------
// Serial frame deframer package
// Shared widths, register indexes and the result item type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int BYTE_W          = 8;
  localparam int POS_W           = 6;
  localparam int LIMIT_W         = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [BYTE_W-1:0]  START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0]  END_MARKER_RST   = 8'h03;
  localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = 7'd64;
  localparam logic [BYTE_W-1:0]  FLEN_MAX         = 8'd63;
  localparam logic [15:0]        CSUM_SEED        = 16'h0055;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_LENGTH_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] len;
  } start_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_index;
    logic [POS_W-1:0]  frame_length;
    logic              last;
  } out_item_t;

endpackage

// ----- hdl/sfd_if.sv -----
// ---------------------------------------------------------------------------
// Serial frame deframer channels
// Valid/ready channels for received bytes and emitted payload bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfd_in_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [POS_W-1:0]  byte_index;
  logic [POS_W-1:0]  frame_length;
  logic              last;
  modport source (output valid, output payload_byte, output byte_index,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input frame_length, input last, output ready);
endinterface

// ----- hdl/sfd_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/sfd_parser.sv -----
// ---------------------------------------------------------------------------
// Serial frame deframer parser
// Frame state machine, checksum, configuration and payload buffer writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_parser #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfd_in_if.sink                        in_ch,
  input  logic                          hold,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
  output logic                          ram_we,
  output logic [$clog2(MAX_PAYLOAD)-1:0] ram_waddr,
  output logic [sfd_pkg::BYTE_W-1:0]    ram_wdata,
  output sfd_pkg::start_req_t           start
);
  import sfd_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_DATA = 6'b000100,
    PH_CSLO = 6'b001000,
    PH_CSHI = 6'b010000,
    PH_END  = 6'b100000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   frame_len_r, frame_len_nxt;
  logic [POS_W-1:0]   write_pos_r, write_pos_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic [BYTE_W-1:0]  start_marker_r, end_marker_r;
  logic [LIMIT_W-1:0] length_limit_r;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              len_bad;
  logic [POS_W-1:0]  pos_inc;
  phase_t            miss_phase;

  assign in_ch.ready = !hold;
  assign accept      = in_ch.valid && !hold;
  assign b           = in_ch.rx_byte;
  assign pos_inc     = write_pos_r + POS_W'(1);
  assign miss_phase  = (b == start_marker_r) ? PH_LEN : PH_IDLE;
  assign len_bad     = (b == '0) ||
                       ({1'b0, b} >= {2'b00, length_limit_r}) ||
                       ({1'b0, b} >= 9'(MAX_PAYLOAD)) ||
                       (b > FLEN_MAX);

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    write_pos_nxt = write_pos_r;
    sum_nxt       = sum_r;
    ram_we        = 1'b0;
    start         = '0;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b == start_marker_r) phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (len_bad) begin
            phase_nxt = miss_phase;
          end else begin
            frame_len_nxt = b[POS_W-1:0];
            write_pos_nxt = '0;
            sum_nxt       = CSUM_SEED + {8'h00, b};
            phase_nxt     = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt       = sum_r + {8'h00, b};
          ram_we        = 1'b1;
          write_pos_nxt = pos_inc;
          if (pos_inc >= frame_len_r) phase_nxt = PH_CSLO;
        end
        PH_CSLO: begin
          phase_nxt = (sum_r[7:0] != b) ? miss_phase : PH_CSHI;
        end
        PH_CSHI: begin
          phase_nxt = (sum_r[15:8] != b) ? miss_phase : PH_END;
        end
        PH_END: begin
          if (b == end_marker_r) begin
            start.valid = 1'b1;
            start.len   = frame_len_r;
            phase_nxt   = PH_IDLE;
          end else begin
            phase_nxt = miss_phase;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign ram_waddr = AW'(write_pos_r);
  assign ram_wdata = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      frame_len_r    <= '0;
      write_pos_r    <= '0;
      sum_r          <= '0;
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
      length_limit_r <= LENGTH_LIMIT_RST;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      write_pos_r <= write_pos_nxt;
      sum_r       <= sum_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_START_MARKER: start_marker_r <= cfg_wdata;
          CFG_END_MARKER:   end_marker_r   <= cfg_wdata;
          CFG_LENGTH_LIMIT: length_limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hdl/sfd_readout.sv -----
// ---------------------------------------------------------------------------
// Serial frame deframer read-out
// Payload buffer read sequencer with a two-entry result queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "serial_frame_deframer_assert.svh"

module sfd_readout #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfd_pkg::start_req_t            start,
  output logic                           hold,
  output logic                           ram_re,
  output logic [$clog2(MAX_PAYLOAD)-1:0] ram_raddr,
  input  logic [sfd_pkg::BYTE_W-1:0]     ram_rdata,
  sfd_out_if.source                      out_ch
);
  import sfd_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [POS_W-1:0] flen_r, flen_nxt;
  logic             infl_r;
  logic [POS_W-1:0] infl_idx_r;
  logic             infl_last_r;
  out_item_t        q_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  logic       pop, push, issue, rd_last;
  logic [1:0] used;
  out_item_t  head;

  assign hold    = busy_r || infl_r;
  assign pop     = out_ch.valid && out_ch.ready;
  assign push    = infl_r;
  assign used    = cnt_r + {1'b0, infl_r};
  assign issue   = busy_r && ((used < 2'd2) || ((used == 2'd2) && pop));
  assign rd_last = (rd_pos_r + POS_W'(1)) == flen_r;

  assign ram_re    = issue;
  assign ram_raddr = AW'(rd_pos_r);

  always_comb begin
    busy_nxt   = busy_r;
    rd_pos_nxt = rd_pos_r;
    flen_nxt   = flen_r;
    if (start.valid) begin
      busy_nxt   = 1'b1;
      rd_pos_nxt = '0;
      flen_nxt   = start.len;
    end else if (issue) begin
      rd_pos_nxt = rd_pos_r + POS_W'(1);
      if (rd_last) busy_nxt = 1'b0;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      infl_r   <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      infl_r <= issue;
      cnt_r  <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r <= rd_pos_nxt;
    flen_r   <= flen_nxt;
    if (issue) begin
      infl_idx_r  <= rd_pos_r;
      infl_last_r <= rd_last;
    end
    if (push) begin
      q_r[wr_ptr_r] <= '{payload_byte: ram_rdata, byte_index: infl_idx_r,
                         frame_length: flen_r, last: infl_last_r};
    end
  end

  assign head                = q_r[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.byte_index   = head.byte_index;
  assign out_ch.frame_length = head.frame_length;
  assign out_ch.last         = head.last;

  `SFD_NEVER(a_queue_overflow, cnt_r == 2'd3)
  `SFD_NEVER(a_start_while_busy, start.valid && (busy_r || infl_r))
  `SFD_ASSERT(a_last_read_ends, (issue && rd_last) |=> (!busy_r && infl_r))
  `SFD_ASSERT(a_read_needs_room, issue |-> (used < 2'd2 || pop))

endmodule

// ----- hdl/serial_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// Serial frame deframer
// Finds start/length/payload/checksum/end frames in a byte stream and
// emits the payload of every verified frame, one byte per result.
//
// in_ch takes one received byte per request; one byte per cycle while
// the block is not reading out a frame. cfg_we/cfg_idx/cfg_wdata write
// start marker, end marker and length limit (indexes 0, 1, 2).
// out_ch carries payload_byte, byte_index, frame_length and last.
// The payload sits in a MAX_PAYLOAD x 8 buffer RAM with registered read.
// After the end marker is accepted, the read-out goes busy, issues the
// first buffer read and queues the registered data; then one byte per
// cycle is offered while out_ch is ready; the buffer's single read port
// sets that rate. in_ch.ready is low from the end marker until the last
// buffer read has returned. A stall on out_ch holds the buffer reads once
// two results are queued or in flight, and so lengthens that window.
// Reset returns the block to waiting for a start marker, restores the
// register defaults and drops any pending results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_deframer #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfd_in_if.sink                        in_ch,
  sfd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata
);
  import sfd_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  logic              hold;
  start_req_t        start;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  sfd_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .hold      (hold),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .start     (start)
  );

  sfd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PAYLOAD)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfd_readout #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_readout (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .hold      (hold),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule
